// ----- rtl/clsc_pkg.sv -----
package clsc_pkg;

    typedef enum logic [1:0] {
        F_META   = 2'd0,
        F_ENTRY  = 2'd1,
        F_LOOKUP = 2'd2,
        F_ACK    = 2'd3
    } t_func;

    localparam logic [2:0] EV_NONE     = 3'd0;
    localparam logic [2:0] EV_REJECT   = 3'd1;
    localparam logic [2:0] EV_UPTODATE = 3'd2;
    localparam logic [2:0] EV_REQUEST  = 3'd3;
    localparam logic [2:0] EV_DONE     = 3'd4;
    localparam logic [2:0] EV_LOOKUP   = 3'd5;
    localparam logic [2:0] EV_ACK      = 3'd6;

    // one input item as held during its execute cycle
    typedef struct packed {
        t_func       func;
        logic [15:0] list_count;
        logic [31:0] list_crc;
        logic [15:0] chunk_start;
        logic [7:0]  chunk_count;
        logic [2:0]  entry_pos;
        logic [15:0] entry_id;
        logic [63:0] entry_name;
        logic [15:0] lookup_index;
        logic [15:0] cur_effect;
    } t_item;

    // what the execute cycle does to the state and the result
    typedef struct packed {
        logic [2:0] ev;
        logic [7:0] req;
        logic       hit;
        logic       wr;
        logic       sync_start;
        logic       sync_stop;
        logic       advance;
        logic       commit;
        logic       ack;
    } t_dec;

endpackage

// ----- rtl/clsc_ram.sv -----
module clsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

// ----- rtl/clsc_decide.sv -----
module clsc_decide #(
    parameter int CACHE_DEPTH = 256,
    parameter int CHUNK_MAX   = 8,
    parameter int CNT_W       = 9,
    parameter int ADDR_W      = 8
) (
    input  clsc_pkg::t_item    i_item,
    input  logic               i_sync_active,
    input  logic [CNT_W-1:0]   i_next_index,
    input  logic [CNT_W-1:0]   i_sync_total,
    input  logic [31:0]        i_sync_checksum,
    input  logic               i_valid_flag,
    input  logic [CNT_W-1:0]   i_committed_count,
    input  logic [31:0]        i_committed_checksum,
    output clsc_pkg::t_dec     o_dec,
    output logic [ADDR_W-1:0]  o_dst,
    output logic [CNT_W-1:0]   o_new_next
);
    import clsc_pkg::*;

    localparam int DW = CNT_W + 3;

    logic              meta_bad;
    logic              meta_match;
    logic              ent_bad;
    logic [CNT_W-1:0]  room;
    logic [CNT_W-1:0]  n_cnt;
    logic [DW-1:0]     dst_full;
    logic              pos_bad;
    logic              last;
    logic              more;

    always_comb begin
        meta_bad   = (i_item.list_count == 16'd0) ||
                     (32'(i_item.list_count) > 32'(CACHE_DEPTH));
        meta_match = i_valid_flag && (32'(i_committed_count) == 32'(i_item.list_count)) &&
                     (i_committed_checksum == i_item.list_crc);

        ent_bad = !i_sync_active || (i_item.list_crc != i_sync_checksum) ||
                  (32'(i_item.chunk_start) != 32'(i_next_index)) ||
                  (i_item.chunk_count == 8'd0) ||
                  (32'(i_item.chunk_count) > 32'(CHUNK_MAX));
        room  = (i_sync_total > i_next_index) ? (i_sync_total - i_next_index) : '0;
        // clamp the chunk to what is left of the list
        n_cnt = (32'(i_item.chunk_count) > 32'(room)) ? room : CNT_W'(i_item.chunk_count);
        dst_full = DW'(i_next_index) + DW'(i_item.entry_pos);
        pos_bad  = (32'(i_item.entry_pos) >= 32'(n_cnt)) || (dst_full >= DW'(CACHE_DEPTH));
        last     = ((DW'(i_item.entry_pos) + DW'(1)) == DW'(n_cnt));
        o_new_next = i_next_index + n_cnt;
        more       = o_new_next < i_sync_total;
        o_dst      = ADDR_W'(dst_full);

        o_dec = '0;
        case (i_item.func)
            F_META: begin
                if (meta_bad) begin
                    o_dec.ev = EV_REJECT;
                end else if (meta_match) begin
                    o_dec.ev        = EV_UPTODATE;
                    o_dec.sync_stop = 1'b1;
                end else begin
                    o_dec.ev         = EV_REQUEST;
                    o_dec.sync_start = 1'b1;
                end
            end
            F_ENTRY: begin
                if (ent_bad || pos_bad) begin
                    o_dec.ev = EV_REJECT;
                end else begin
                    o_dec.wr = 1'b1;
                    o_dec.ev = EV_NONE;
                    if (last) begin
                        o_dec.advance = 1'b1;
                        if (more) begin
                            o_dec.ev  = EV_REQUEST;
                            o_dec.req = 8'(o_new_next);
                        end else begin
                            o_dec.ev        = EV_DONE;
                            o_dec.commit    = 1'b1;
                            o_dec.sync_stop = 1'b1;
                        end
                    end
                end
            end
            F_LOOKUP: begin
                o_dec.ev  = EV_LOOKUP;
                o_dec.hit = i_valid_flag &&
                            (32'(i_item.lookup_index) < 32'(i_committed_count));
            end
            F_ACK: begin
                o_dec.ev  = EV_ACK;
                o_dec.ack = 1'b1;
            end
            default: begin
                o_dec.ev = EV_NONE;
            end
        endcase
    end

endmodule

// ----- rtl/chunked_list_sync_cache_unit.sv -----
// Cached list synced in chunks from a peer device. Entries (16-bit id plus
// name word) live in one synchronous RAM of CACHE_DEPTH words. After reset a
// clearing pass writes zeros to every RAM word, one per cycle; input stays
// stalled during it. Each item then passes an accept step and an execute
// step: the accept cycle issues the RAM read for a lookup, the execute
// cycle decides, writes a chunk entry back and loads the result register.
// The result register lets the next item be accepted while a result waits;
// execute holds while the previous result is still stalled.
module chunked_list_sync_cache_unit #(
    parameter int CACHE_DEPTH = 256,
    parameter int CHUNK_MAX   = 8,
    parameter int NAME_BYTES  = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_func,
    input  logic [15:0] i_list_count,
    input  logic [31:0] i_list_crc,
    input  logic [15:0] i_chunk_start,
    input  logic [7:0]  i_chunk_count,
    input  logic [2:0]  i_entry_pos,
    input  logic [15:0] i_entry_id,
    input  logic [63:0] i_entry_name,
    input  logic [15:0] i_lookup_index,
    input  logic [15:0] i_cur_effect,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_event_res,
    output logic [7:0]  o_request_index,
    output logic        o_found,
    output logic [15:0] o_found_id,
    output logic [63:0] o_found_name,
    output logic        o_cache_valid,
    output logic [8:0]  o_cache_count,
    output logic [15:0] o_last_effect
);
    import clsc_pkg::*;

    localparam int CNT_W  = $clog2(CACHE_DEPTH + 1);
    localparam int ADDR_W = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
    localparam int NW     = 8 * (NAME_BYTES - 1);
    localparam int WW     = 16 + NW;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } t_state;

    t_state            r_state;
    logic [ADDR_W-1:0] r_clr_addr;
    t_item             r_item;

    logic              r_sync_active;
    logic [CNT_W-1:0]  r_next_index;
    logic [CNT_W-1:0]  r_sync_total;
    logic [31:0]       r_sync_checksum;
    logic              r_valid_flag;
    logic [CNT_W-1:0]  r_committed_count;
    logic [31:0]       r_committed_checksum;
    logic [15:0]       r_effect;

    logic              r_out_valid;
    logic [2:0]        r_out_ev;
    logic [7:0]        r_out_req;
    logic              r_out_found;
    logic [15:0]       r_out_id;
    logic [63:0]       r_out_name;
    logic              r_out_cvalid;
    logic [8:0]        r_out_ccount;
    logic [15:0]       r_out_effect;

    t_dec              dec;
    logic [ADDR_W-1:0] dst;
    logic [CNT_W-1:0]  new_next;
    logic              accept;
    logic              exec_done;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [WW-1:0]     ram_wdata;
    logic [WW-1:0]     ram_rdata;

    logic              n_valid_flag;
    logic [CNT_W-1:0]  n_committed_count;
    logic [15:0]       n_effect;
    logic [31:0]       n_count_ext;

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign exec_done  = (r_state == S_EXEC) && (!r_out_valid || !i_out_stall);

    clsc_decide #(
        .CACHE_DEPTH (CACHE_DEPTH),
        .CHUNK_MAX   (CHUNK_MAX),
        .CNT_W       (CNT_W),
        .ADDR_W      (ADDR_W)
    ) u_decide (
        .i_item               (r_item),
        .i_sync_active        (r_sync_active),
        .i_next_index         (r_next_index),
        .i_sync_total         (r_sync_total),
        .i_sync_checksum      (r_sync_checksum),
        .i_valid_flag         (r_valid_flag),
        .i_committed_count    (r_committed_count),
        .i_committed_checksum (r_committed_checksum),
        .o_dec                (dec),
        .o_dst                (dst),
        .o_new_next           (new_next)
    );

    always_comb begin
        if (r_state == S_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = '0;
        end else begin
            ram_we    = exec_done && dec.wr;
            ram_waddr = dst;
            // drop the top name byte and everything above it
            ram_wdata = {r_item.entry_id, r_item.entry_name[NW-1:0]};
        end
    end

    clsc_ram #(
        .WIDTH (WW),
        .DEPTH (CACHE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (accept),
        .i_raddr (ADDR_W'(i_lookup_index)),
        .o_rdata (ram_rdata)
    );

    // committed view after this item
    always_comb begin
        n_valid_flag      = dec.commit ? 1'b1 : r_valid_flag;
        n_committed_count = dec.commit ? r_sync_total : r_committed_count;
        n_effect          = dec.ack ? r_item.cur_effect : r_effect;
        n_count_ext       = n_valid_flag ? 32'(n_committed_count) : 32'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state              <= S_CLEAR;
            r_clr_addr           <= '0;
            r_sync_active        <= 1'b0;
            r_next_index         <= '0;
            r_sync_total         <= '0;
            r_sync_checksum      <= '0;
            r_valid_flag         <= 1'b0;
            r_committed_count    <= '0;
            r_committed_checksum <= '0;
            r_effect             <= '0;
            r_out_valid          <= 1'b0;
        end else begin
            if (exec_done) begin
                r_out_valid <= 1'b1;
            end else if (o_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + ADDR_W'(1);
                    if (r_clr_addr == ADDR_W'(CACHE_DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (exec_done) begin
                        r_state <= S_IDLE;
                        if (dec.sync_start) begin
                            r_sync_active   <= 1'b1;
                            r_next_index    <= '0;
                            r_sync_total    <= CNT_W'(r_item.list_count);
                            r_sync_checksum <= r_item.list_crc;
                        end
                        if (dec.sync_stop) begin
                            r_sync_active <= 1'b0;
                        end
                        if (dec.advance) begin
                            r_next_index <= new_next;
                        end
                        if (dec.commit) begin
                            r_committed_count    <= r_sync_total;
                            r_committed_checksum <= r_sync_checksum;
                            r_valid_flag         <= 1'b1;
                        end
                        r_effect <= n_effect;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= '{
                func:         t_func'(i_func),
                list_count:   i_list_count,
                list_crc:     i_list_crc,
                chunk_start:  i_chunk_start,
                chunk_count:  i_chunk_count,
                entry_pos:    i_entry_pos,
                entry_id:     i_entry_id,
                entry_name:   i_entry_name,
                lookup_index: i_lookup_index,
                cur_effect:   i_cur_effect
            };
        end
        if (exec_done) begin
            r_out_ev     <= dec.ev;
            r_out_req    <= dec.req;
            r_out_found  <= dec.hit;
            r_out_id     <= dec.hit ? ram_rdata[WW-1:NW] : 16'd0;
            r_out_name   <= dec.hit ? 64'(ram_rdata[NW-1:0]) : 64'd0;
            r_out_cvalid <= n_valid_flag;
            r_out_ccount <= n_count_ext[8:0];
            r_out_effect <= n_effect;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_event_res     = r_out_ev;
    assign o_request_index = r_out_req;
    assign o_found         = r_out_found;
    assign o_found_id      = r_out_id;
    assign o_found_name    = r_out_name;
    assign o_cache_valid   = r_out_cvalid;
    assign o_cache_count   = r_out_ccount;
    assign o_last_effect   = r_out_effect;

    a_next_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sync_active |-> (r_next_index <= r_sync_total))
        else $error("sync index ran past the announced total");

    a_commit_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid_flag |-> (r_committed_count != '0))
        else $error("valid cache with zero entries");

    a_no_write_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> !ram_we)
        else $error("entry write collides with lookup read");

    a_result_from_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_EXEC))
        else $error("result loaded outside execute");

endmodule
